@@ rtl/sha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, opcodes, state encoding, initial hash values and round constants.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam logic [1:0] OP_ABSORB     = 2'd0;
    localparam logic [1:0] OP_ABSORB_FIN = 2'd1;
    localparam logic [1:0] OP_FINISH     = 2'd2;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    // Phases of the compression core.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOAD,
        PH_ROUND,
        PH_ADD
    } phase_t;

    function automatic logic [31:0] initial_hash(input logic [2:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                3'd0: r = 32'h6a09e667;
                3'd1: r = 32'hbb67ae85;
                3'd2: r = 32'h3c6ef372;
                3'd3: r = 32'ha54ff53a;
                3'd4: r = 32'h510e527f;
                3'd5: r = 32'h9b05688c;
                3'd6: r = 32'h1f83d9ab;
                default: r = 32'h5be0cd19;
            endcase
            return r;
        end
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

endpackage
`default_nettype wire

@@ rtl/sha_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Holds the 64-byte block buffer as a memory and the hash words, and runs one
// round per cycle with a sixteen-word message schedule window.
// ----------------------------------------------------------------------------
module sha_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              buf_we,
    input  wire logic [5:0]        buf_addr,
    input  wire logic [7:0]        buf_data,
    input  wire logic              start,
    input  wire logic              restart,
    input  wire logic [2:0]        hash_sel,
    output logic [31:0]            hash_word,
    output logic                   busy
);
    import sha_pkg::*;

    logic [7:0]  buf_mem [64];
    logic [7:0]  rd_data_reg;
    logic [5:0]  rd_addr;
    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] wbuild_reg;
    logic [6:0]  cnt_reg;
    phase_t      phase_reg, phase_next;
    logic [31:0] w_cur, w_new, t1, t2, big0, big1, s0, s1, ch, mj;
    logic [5:0]  rnd;

    // Buffer memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_addr] <= buf_data;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    // Busy comes from the phase register only, so it never depends on start.
    assign rd_addr = cnt_reg[5:0];
    assign busy = (phase_reg != PH_IDLE);
    assign hash_word = hash_reg[hash_sel];

    // Loading stage reads one byte per cycle; round t uses the schedule.
    assign rnd = cnt_reg[5:0];
    always_comb
    begin
        s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
             ^ (w_reg[1] >> 3);
        s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
             ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = w_reg[0];
        big1 = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
               ^ {v_reg[4][24:0], v_reg[4][31:25]};
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big1 + ch + ROUND_K[rnd] + w_cur;
        big0 = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
               ^ {v_reg[0][21:0], v_reg[0][31:22]};
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big0 + mj;
    end

    // Next phase: load, rounds, final addition, back to idle.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_LOAD;
                end
            end
            PH_LOAD:
            begin
                if (cnt_reg == 7'd64)
                begin
                    phase_next = PH_ROUND;
                end
            end
            PH_ROUND:
            begin
                if (cnt_reg == 7'd63)
                begin
                    phase_next = PH_ADD;
                end
            end
            PH_ADD:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Sequencing of load, rounds and final addition.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= initial_hash(3'(i));
            end
        end
        else
        begin
            phase_reg <= phase_next;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    cnt_reg <= '0;
                    if (restart)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            hash_reg[i] <= initial_hash(3'(i));
                        end
                    end
                    if (start)
                    begin
                        cnt_reg <= 7'd1;
                    end
                end
                PH_LOAD:
                begin
                    // Byte read at cnt-1 arrives now; pack into words.
                    if (cnt_reg[1:0] == 2'd0)
                    begin
                        for (int i = 0; i < 15; i++)
                        begin
                            w_reg[i] <= w_reg[i + 1];
                        end
                        w_reg[15] <= {wbuild_reg[23:0], rd_data_reg};
                    end
                    wbuild_reg <= {wbuild_reg[23:0], rd_data_reg};
                    if (cnt_reg == 7'd64)
                    begin
                        cnt_reg <= '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            v_reg[i] <= hash_reg[i];
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                PH_ROUND:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= w_new;
                    cnt_reg <= cnt_reg + 7'd1;
                end
                PH_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Absorbs one byte per beat, pads on finish and emits the eight digest words.
// ----------------------------------------------------------------------------
// Absorb: an absorb beat writes the buffer; a beat that fills the block starts
// a compression in the core (64 buffer reads, 64 rounds and one addition).
// Finish: padding writes one byte a cycle, then one or two compressions,
// then eight output beats. Input is not taken while the core is busy.
// Reset: hash words take the initial values, counts clear; buffer is not
// cleared.
module sha256_stream_hasher (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sha_pkg::in_beat_t   in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sha_pkg::out_beat_t       out_data
);
    import sha_pkg::*;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [63:0] len_reg, len_next;
    logic [2:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic        buf_we, start, restart, busy;
    logic [5:0]  buf_addr;
    logic [7:0]  buf_data;
    logic [31:0] hash_word;
    logic [2:0]  len_byte;
    logic        accept;

    sha_core u_core (
        .clk(clk), .rst_n(rst_n), .buf_we(buf_we), .buf_addr(buf_addr),
        .buf_data(buf_data), .start(start), .restart(restart),
        .hash_sel(idx_reg), .hash_word(hash_word), .busy(busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
        end
    end

    assign accept = in_valid && in_ready;
    assign len_byte = 3'(fill_reg - LEN_POS);
    assign out_data.digest_word = hash_word;
    assign out_data.word_index  = idx_reg;
    assign out_data.last_word   = (idx_reg == 3'd7);

    // Sequencer: absorb, padding, waiting on the core and digest output.
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        buf_we     = 1'b0;
        buf_addr   = fill_reg;
        buf_data   = in_data.data_byte;
        start      = 1'b0;
        restart    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !busy;
                if (accept && in_data.opcode != OP_UNUSED)
                begin
                    if (in_data.opcode != OP_FINISH)
                    begin
                        buf_we    = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                        start     = (fill_reg == 6'd63);
                    end
                    if (in_data.opcode != OP_ABSORB)
                    begin
                        len_next   = (in_data.opcode == OP_FINISH) ? bits_reg
                                     : bits_reg + 64'd8;
                        fin_next   = 1'b1;
                        state_next = (fill_reg == 6'd63 && in_data.opcode == OP_ABSORB_FIN)
                                     ? ST_LOAD : ST_PAD;
                    end
                end
            end
            ST_LOAD:
            begin
                // Wait for a block compression before writing more padding.
                if (!busy)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (!busy)
                begin
                    buf_we    = 1'b1;
                    buf_data  = fin_reg ? PAD_BYTE : 8'h00;
                    fin_next  = 1'b0;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        start      = 1'b1;
                        state_next = ST_ROUND;
                    end
                    else if (fill_reg + 6'd1 == LEN_POS)
                    begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_ROUND:
            begin
                if (!busy)
                begin
                    state_next = (fill_reg == LEN_POS) ? ST_LEN : ST_PAD;
                end
            end
            ST_LEN:
            begin
                buf_we    = 1'b1;
                buf_data  = len_reg[63 - 8 * len_byte -: 8];
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                begin
                    start      = 1'b1;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (!busy)
                begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                end
            end
            default:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        restart    = 1'b1;
                        fill_next  = '0;
                        bits_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end
endmodule
`default_nettype wire

@@ test/tb_sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte beats with bursty gaps against a stalling receiver and checks
// every digest word against a behavioural SHA-256 model kept in step here.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;
    import sha_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    sha256_stream_hasher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Model state of the hasher.
    logic [31:0] mdl_hash [8];
    logic [7:0]  mdl_buf [64];
    logic [5:0]  mdl_fill;
    logic [63:0] mdl_bits;

    out_beat_t   digest_q [$];
    int          err_count;

    // Directed rows; a known first digest word is given where it is read at a glance.
    typedef struct {
        logic [1:0]  op;
        logic [7:0]  byte_v;
        logic        has_known;
        logic [31:0] known_w0;
    } row_t;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] init_word(input int i);
        logic [31:0] iv [8];
        iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return iv[i];
    endfunction

    function automatic logic [31:0] k_const(input int i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[i];
    endfunction

    task automatic restart_model();
        for (int i = 0; i < 8; i++) mdl_hash[i] = init_word(i);
        mdl_fill = '0;
        mdl_bits = '0;
    endtask

    // One 64-round compression of the model buffer.
    task automatic compress_model();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {mdl_buf[4*t], mdl_buf[4*t+1], mdl_buf[4*t+2], mdl_buf[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int t = 0; t < 8; t++) v[t] = mdl_hash[t];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(t) + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) mdl_hash[t] += v[t];
    endtask

    task automatic push_model_byte(input logic [7:0] b);
        mdl_buf[mdl_fill] = b;
        mdl_fill = mdl_fill + 6'd1;
        if (mdl_fill == 6'd0) compress_model();
    endtask

    // Applies one accepted beat and queues the digest words it produces.
    task automatic hash_beat(input in_beat_t beat);
        logic [63:0] len;
        out_beat_t   o;
        if (beat.opcode == OP_UNUSED) return;
        if (beat.opcode != OP_FINISH) begin
            mdl_bits += 64'd8;
            push_model_byte(beat.data_byte);
        end
        if (beat.opcode == OP_ABSORB) return;
        len = mdl_bits;
        push_model_byte(PAD_BYTE);
        while (mdl_fill != LEN_POS) push_model_byte(8'h00);
        for (int i = 0; i < 8; i++) mdl_buf[56+i] = len[63-8*i -: 8];
        compress_model();
        for (int i = 0; i < 8; i++) begin
            o.digest_word = mdl_hash[i];
            o.word_index  = 3'(i);
            o.last_word   = (i == 7);
            digest_q.push_back(o);
        end
        restart_model();
    endtask

    // Receiver stalls at random, apart from stall-free stretches in a repeating pattern.
    int stall_phase;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready   <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= (stall_phase + 1) % 97;
            if (stall_phase < 30)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Check each accepted output beat against the oldest expected word.
    always @(posedge clk) begin
        out_beat_t exp_w;
        if (rst_n && out_valid && out_ready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected output beat %h", $time, out_data);
                err_count++;
            end else begin
                exp_w = digest_q.pop_front();
                if (out_data.digest_word !== exp_w.digest_word) begin
                    $display("%0t: digest_word expected %h actual %h", $time,
                             exp_w.digest_word, out_data.digest_word);
                    err_count++;
                end
                if (out_data.word_index !== exp_w.word_index) begin
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             exp_w.word_index, out_data.word_index);
                    err_count++;
                end
                if (out_data.last_word !== exp_w.last_word) begin
                    $display("%0t: last_word expected %0d actual %0d", $time,
                             exp_w.last_word, out_data.last_word);
                    err_count++;
                end
            end
        end
    end

    // Presents one beat and holds it until accepted; bursts gap at random.
    int burst_left;
    int sent;
    task automatic send_beat(input in_beat_t beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        hash_beat(beat);
        sent++;
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    // A random message: mostly absorbs, ending in a finish or an absorb with finish.
    task automatic send_message(input int len_max);
        in_beat_t b;
        int       n;
        n = $urandom_range(0, len_max);
        for (int i = 0; i < n; i++) begin
            b.opcode    = ($urandom_range(0, 19) == 0) ? OP_UNUSED : OP_ABSORB;
            b.data_byte = 8'($urandom);
            send_beat(b);
        end
        b.opcode    = ($urandom_range(0, 1) != 0) ? OP_ABSORB_FIN : OP_FINISH;
        b.data_byte = 8'($urandom);
        send_beat(b);
    endtask

    // Padding edges: absorbed byte count ahead of the closing beat.
    int         pad_len [3] = '{55, 55, 63};
    logic [1:0] pad_op [3]  = '{OP_FINISH, OP_ABSORB_FIN, OP_ABSORB_FIN};

    row_t     rows [$];
    in_beat_t beat;
    int       guard;

    initial begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        err_count  = 0;
        burst_left = 0;
        sent       = 0;
        restart_model();
        for (int i = 0; i < 64; i++) mdl_buf[i] = 8'h00;

        // Empty message, unused opcode, extreme bytes, the string "abc".
        rows.push_back('{OP_FINISH,     8'hff, 1'b1, 32'he3b0c442});
        rows.push_back('{OP_UNUSED,     8'h5a, 1'b0, 32'h0});
        rows.push_back('{OP_FINISH,     8'h00, 1'b1, 32'he3b0c442});
        rows.push_back('{OP_ABSORB,     8'h61, 1'b0, 32'h0});
        rows.push_back('{OP_ABSORB,     8'h62, 1'b0, 32'h0});
        rows.push_back('{OP_UNUSED,     8'h00, 1'b0, 32'h0});
        rows.push_back('{OP_ABSORB_FIN, 8'h63, 1'b1, 32'hba7816bf});
        rows.push_back('{OP_ABSORB_FIN, 8'h00, 1'b0, 32'h0});
        rows.push_back('{OP_ABSORB_FIN, 8'hff, 1'b0, 32'h0});
        rows.push_back('{OP_ABSORB,     8'h00, 1'b0, 32'h0});
        rows.push_back('{OP_ABSORB,     8'hff, 1'b0, 32'h0});
        rows.push_back('{OP_FINISH,     8'haa, 1'b0, 32'h0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r]) begin
            beat.opcode    = rows[r].op;
            beat.data_byte = rows[r].byte_v;
            send_beat(beat);
            if (rows[r].has_known) begin
                if (digest_q.size() < 8) begin
                    $display("%0t: row %0d first word expected %h actual none", $time,
                             r, rows[r].known_w0);
                    err_count++;
                end else if (digest_q[digest_q.size() - 8].digest_word
                             !== rows[r].known_w0) begin
                    $display("%0t: row %0d first word expected %h actual %h", $time, r,
                             rows[r].known_w0, digest_q[digest_q.size() - 8].digest_word);
                    err_count++;
                end
            end
        end

        // Padding edges: finish at fill 55 and 56, and a block filled by the
        // closing byte itself.
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < pad_len[j]; i++) begin
                beat.opcode    = OP_ABSORB;
                beat.data_byte = 8'($urandom);
                send_beat(beat);
            end
            beat.opcode    = pad_op[j];
            beat.data_byte = 8'($urandom);
            send_beat(beat);
        end

        // Random messages, most short, a few spanning several blocks.
        while (sent < 330) begin
            if ($urandom_range(0, 9) == 0)
                send_message(150);
            else
                send_message(20);
        end
        drop_valid();

        guard = 0;
        while (digest_q.size() != 0 && guard < 20000) begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);

        if (err_count == 0 && digest_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
